// ===== src/onewire_temp_scratchpad_decoder_top_macros.svh =====
// assertion macros for the one-wire scratchpad decoder
`ifndef ONEWIRE_TEMP_SCRATCHPAD_DECODER_TOP_MACROS_SVH
`define ONEWIRE_TEMP_SCRATCHPAD_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define OWTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owts check failed");
`define OWTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owts check failed");
`else
`define OWTS_ASSERT_NOW(label, ante, cons)
`define OWTS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/owts_pkg.sv =====
// types and constants of the one-wire scratchpad decoder
package owts_pkg;

    localparam int unsigned NUM_POINTS = 8;
    localparam int unsigned MUL_STEPS  = 12;
    localparam int unsigned DIV_STEPS  = 12;

    localparam logic        REQ_PRESENCE = 1'b0;
    localparam logic        REQ_SLOT     = 1'b1;

    localparam logic [1:0]  STAT_OK    = 2'd0;
    localparam logic [1:0]  STAT_NODEV = 2'd1;
    localparam logic [1:0]  STAT_BAD   = 2'd2;

    localparam logic [7:0]  NODEV_ECHO = 8'hF0;
    localparam logic [7:0]  SLOT_ONE   = 8'hFF;
    localparam logic [7:0]  MAGIC_B5   = 8'hFF;
    localparam logic [7:0]  MAGIC_B7   = 8'h10;
    localparam logic [7:0]  CRC_POLY   = 8'h8C;

    localparam logic [3:0]  BYTE_LOW   = 4'd0;
    localparam logic [3:0]  BYTE_HIGH  = 4'd1;
    localparam logic [3:0]  BYTE_M5    = 4'd5;
    localparam logic [3:0]  BYTE_M7    = 4'd7;
    localparam logic [3:0]  BYTE_CRC   = 4'd8;
    localparam logic [6:0]  MAX_SLOT   = 7'd71;

    localparam logic signed [16:0] ERR_TEMP = 17'sd25574;
    localparam logic signed [15:0] T_TOP    = 16'sd17920;
    localparam logic [14:0] POINT_STEP      = 15'd2560;
    localparam logic [20:0] HALF_STEP       = 21'd1280;
    localparam logic [11:0] DIV_OFFSET      = 12'd1280;
    localparam logic [11:0] QUOT_BIAS       = 12'd256;
    localparam logic [3:0]  DIVISOR         = 4'd5;

    localparam logic [7:0] CORR_RESET [NUM_POINTS] = '{
        8'd38, 8'd46, 8'd51, 8'd46, 8'd36, 8'd18, 8'hFD, 8'hDC
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEG,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ===== src/onewire_temp_scratchpad_decoder_top.sv =====
// one-wire temperature scratchpad decoder: slot assembly, crc-8 check, correction
// A presence request that echoes no device, or a frame that fails its magic or crc
// check, gives its result on the next cycle. A good frame end runs the correction
// through a segment search, a bit-serial multiply and a bit-serial divide by five,
// then registers the result once the output register is free; no new request is
// taken until then. Readings at or below 0 degC or at or above 70 degC skip
// straight to the result. A new request is taken while a result waits, as long as
// the output register frees in that cycle.
`include "onewire_temp_scratchpad_decoder_top_macros.svh"

module onewire_temp_scratchpad_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] echo_byte
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [16:0] temperature, [23:17] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import owts_pkg::*;

    state_t             state_reg, state_next;
    logic [6:0]         slot_count_reg, slot_count_next;
    logic [7:0]         asm_reg, asm_next;
    logic [7:0]         crc_reg, crc_next;
    logic [7:0]         rd_low_reg, rd_low_next;
    logic [7:0]         rd_high_reg, rd_high_next;
    logic               magic_ok_reg, magic_ok_next;
    logic [7:0]         corr_reg [NUM_POINTS];

    logic signed [15:0] t_reg, t_next;
    logic [14:0]        rem_reg, rem_next;
    logic [2:0]         seg_reg, seg_next;
    logic signed [20:0] mcand_reg, mcand_next;
    logic signed [20:0] acc_reg, acc_next;
    logic [11:0]        mplier_reg, mplier_next;
    logic [11:0]        dvd_reg, dvd_next;
    logic [2:0]         div_r_reg, div_r_next;
    logic [3:0]         cnt_reg, cnt_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic signed [16:0] out_temp_reg, out_temp_next;

    logic               in_acc;
    logic               out_free;
    logic               slot_bit;
    logic [7:0]         crc_shift;
    logic [7:0]         asm_new;
    logic [3:0]         byte_idx;
    logic               byte_end;
    logic signed [15:0] t_new;
    logic [7:0]         c_lo, c_hi;
    logic signed [8:0]  diff;
    logic signed [20:0] acc_sum;
    logic [3:0]         r_try;
    logic               r_ge;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;

    assign slot_bit  = (s_axis_tdata == SLOT_ONE);
    assign crc_shift = {1'b0, crc_reg[7:1]} ^ ((crc_reg[0] ^ slot_bit) ? CRC_POLY : 8'h00);
    assign asm_new   = {slot_bit, asm_reg[7:1]};
    assign byte_idx  = slot_count_reg[6:3];
    assign byte_end  = (slot_count_reg[2:0] == 3'd7);
    assign t_new     = {rd_high_reg[3:0], rd_low_reg, 4'b0000};

    assign c_lo    = corr_reg[seg_reg];
    assign c_hi    = corr_reg[seg_reg + 3'd1];
    assign diff    = $signed({c_hi[7], c_hi}) - $signed({c_lo[7], c_lo});
    assign acc_sum = acc_reg + (mplier_reg[0] ? mcand_reg : 21'sd0);
    assign r_try   = {div_r_reg, dvd_reg[11]};
    assign r_ge    = (r_try >= DIVISOR);

    always_comb
    begin
        state_next      = state_reg;
        slot_count_next = slot_count_reg;
        asm_next        = asm_reg;
        crc_next        = crc_reg;
        rd_low_next     = rd_low_reg;
        rd_high_next    = rd_high_reg;
        magic_ok_next   = magic_ok_reg;
        t_next          = t_reg;
        rem_next        = rem_reg;
        seg_next        = seg_reg;
        mcand_next      = mcand_reg;
        acc_next        = acc_reg;
        mplier_next     = mplier_reg;
        dvd_next        = dvd_reg;
        div_r_next      = div_r_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_temp_next   = out_temp_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (s_axis_tuser == REQ_PRESENCE))
                begin
                    slot_count_next = '0;
                    asm_next        = '0;
                    crc_next        = '0;
                    rd_low_next     = '0;
                    rd_high_next    = '0;
                    magic_ok_next   = 1'b1;
                    if (s_axis_tdata == NODEV_ECHO)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_NODEV;
                        out_temp_next   = ERR_TEMP;
                    end
                end
                else if (in_acc)
                begin
                    asm_next        = asm_new;
                    slot_count_next = slot_count_reg + 7'd1;
                    if (byte_idx < BYTE_CRC)
                    begin
                        crc_next = crc_shift;
                    end
                    if (byte_end)
                    begin
                        case (byte_idx)
                            BYTE_LOW:  rd_low_next = asm_new;
                            BYTE_HIGH: rd_high_next = asm_new;
                            BYTE_M5:
                            begin
                                if (asm_new != MAGIC_B5)
                                begin
                                    magic_ok_next = 1'b0;
                                end
                            end
                            BYTE_M7:
                            begin
                                if (asm_new != MAGIC_B7)
                                begin
                                    magic_ok_next = 1'b0;
                                end
                            end
                            BYTE_CRC:
                            begin
                                slot_count_next = '0;
                                asm_next        = '0;
                                crc_next        = '0;
                                rd_low_next     = '0;
                                rd_high_next    = '0;
                                magic_ok_next   = 1'b1;
                                t_next          = t_new;
                                seg_next        = '0;
                                dvd_next        = QUOT_BIAS;
                                rem_next        = t_new[14:0];
                                if (!magic_ok_reg || (asm_new != crc_reg))
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = STAT_BAD;
                                    out_temp_next   = ERR_TEMP;
                                end
                                else if (t_new <= 16'sd0)
                                begin
                                    state_next = ST_DONE;
                                end
                                else if (t_new >= T_TOP)
                                begin
                                    seg_next   = 3'd7;
                                    state_next = ST_DONE;
                                end
                                else
                                begin
                                    state_next = ST_SEG;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end

            ST_SEG:
            begin
                if (rem_reg >= POINT_STEP)
                begin
                    rem_next = rem_reg - POINT_STEP;
                    seg_next = seg_reg + 3'd1;
                end
                else
                begin
                    mcand_next  = {{12{diff[8]}}, diff};
                    mplier_next = rem_reg[11:0];
                    acc_next    = HALF_STEP;
                    cnt_next    = 4'(MUL_STEPS - 1);
                    state_next  = ST_MUL;
                end
            end

            ST_MUL:
            begin
                acc_next    = acc_sum;
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    dvd_next   = acc_sum[20:9] + DIV_OFFSET;
                    div_r_next = '0;
                    cnt_next   = 4'(DIV_STEPS - 1);
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                div_r_next = r_ge ? 3'(r_try - DIVISOR) : r_try[2:0];
                dvd_next   = {dvd_reg[10:0], r_ge};
                cnt_next   = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_temp_next   = {t_reg[15], t_reg}
                                    + {{9{c_lo[7]}}, c_lo}
                                    + {5'b0, dvd_reg}
                                    - {5'b0, QUOT_BIAS};
                    state_next      = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= '0;
            asm_reg        <= '0;
            crc_reg        <= '0;
            rd_low_reg     <= '0;
            rd_high_reg    <= '0;
            magic_ok_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
            corr_reg       <= CORR_RESET;
        end
        else
        begin
            slot_count_reg <= slot_count_next;
            asm_reg        <= asm_next;
            crc_reg        <= crc_next;
            rd_low_reg     <= rd_low_next;
            rd_high_reg    <= rd_high_next;
            magic_ok_reg   <= magic_ok_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                corr_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg          <= t_next;
        rem_reg        <= rem_next;
        seg_reg        <= seg_next;
        mcand_reg      <= mcand_next;
        acc_reg        <= acc_next;
        mplier_reg     <= mplier_next;
        dvd_reg        <= dvd_next;
        div_r_reg      <= div_r_next;
        cnt_reg        <= cnt_next;
        out_status_reg <= out_status_next;
        out_temp_reg   <= out_temp_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {7'b0, out_temp_reg};

    `OWTS_ASSERT_NEXT(a_nodev_result, in_acc && (s_axis_tuser == REQ_PRESENCE) && (s_axis_tdata == NODEV_ECHO), m_axis_tvalid && (m_axis_tuser == STAT_NODEV))
    `OWTS_ASSERT_NEXT(a_done_result, (state_reg == ST_DONE) && out_free, m_axis_tvalid && (m_axis_tuser == STAT_OK) && (state_reg == ST_IDLE))
    `OWTS_ASSERT_NOW(a_slot_range, 1'b1, slot_count_reg <= MAX_SLOT)

endmodule
